// File: rtl/nmrp_pkg.sv
// ----------------------------------------------------------------------------
// nmrp_pkg : shared types and constants for the NDEF record parser
// Field kinds (also used as parse phase), status codes, result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package nmrp_pkg;

  localparam int MaxRecordsDefault = 16;
  localparam int LimitW            = 5;
  localparam logic [LimitW-1:0] RecordLimitReset = 5'd16;

  // header flag bit positions
  localparam int FlagMb = 7;
  localparam int FlagMe = 6;
  localparam int FlagCf = 5;
  localparam int FlagSr = 4;
  localparam int FlagIl = 3;

  // field kind of a byte; the parse phase uses the same encoding
  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_TYPE_LEN = 3'd1,
    KIND_PAY_LEN  = 3'd2,
    KIND_ID_LEN   = 3'd3,
    KIND_TYPE     = 3'd4,
    KIND_ID       = 3'd5,
    KIND_PAYLOAD  = 3'd6,
    KIND_IGNORED  = 3'd7
  } field_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  byte_value;
    field_kind_t field_kind;
    logic [3:0]  record_index;
    logic [2:0]  record_tnf;
    logic        begin_flag;
    logic        chunk_flag;
    logic        record_done;
    logic        message_done;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/ndef_message_record_parser.sv
// An accepted byte goes first into the input register and then into the result
// register once that is empty or being drained by out_ready.
// Throughput: one byte per cycle while out_ready is not held low; the parse state is updated in a single step.
// Input register and result register each hold one beat, so one more input
// beat can be taken while a finished result waits for out_ready.
// Reset (rst, synchronous): parse state cleared, both registers empty,
// record_limit back to 16.
// ----------------------------------------------------------------------------
// ndef_message_record_parser : NDEF message byte tagger
// Tags every message byte with field kind, record index, flags and status.
// ----------------------------------------------------------------------------
`default_nettype none

module ndef_message_record_parser #(
  parameter int MAX_RECORDS = nmrp_pkg::MaxRecordsDefault
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // config
  input  wire logic                        cfg_we,
  input  wire logic [nmrp_pkg::LimitW-1:0] cfg_wdata,
  // input beats
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        last_byte,
  // result beats
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       byte_value,
  output logic [2:0]                       field_kind,
  output logic [3:0]                       record_index,
  output logic [2:0]                       record_tnf,
  output logic                             begin_flag,
  output logic                             chunk_flag,
  output logic                             record_done,
  output logic                             message_done,
  output logic [1:0]                       status
);
  import nmrp_pkg::*;

  logic [LimitW-1:0] record_limit;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;

  // result register
  result_t    out_res;
  result_t    step_res;
  logic       advance;

  // move a beat from the input register into the result register when
  // the result register is empty or being drained this cycle
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      record_limit <= RecordLimitReset;
    end else if (cfg_we) begin
      record_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= data_byte;
      in_last <= last_byte;
    end
  end

  nmrp_core #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .data_byte    (in_byte),
    .last_byte    (in_last),
    .record_limit (record_limit),
    .result       (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign byte_value   = out_res.byte_value;
  assign field_kind   = out_res.field_kind;
  assign record_index = out_res.record_index;
  assign record_tnf   = out_res.record_tnf;
  assign begin_flag   = out_res.begin_flag;
  assign chunk_flag   = out_res.chunk_flag;
  assign record_done  = out_res.record_done;
  assign message_done = out_res.message_done;
  assign status       = out_res.status;

  // message end only ever closes a record
  a_msg_closes_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.message_done |-> out_res.record_done)
    else $error("message_done without record_done");

  // ignored bytes carry no marks and a clean status
  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.field_kind == KIND_IGNORED |->
      !out_res.record_done && out_res.status == ST_OK)
    else $error("ignored byte carries marks or status");

  // a held result blocks the input register when it is full
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_full |-> !in_ready)
    else $error("input taken while both registers full");

  // every beat moved on shows up as a result
  a_advance_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  // a truncated byte never also ends its record
  a_trunc_not_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.status == ST_TRUNCATED |-> !out_res.record_done)
    else $error("truncated byte marked record_done");

endmodule

`default_nettype wire

// File: rtl/nmrp_core.sv
// ----------------------------------------------------------------------------
// nmrp_core : per-byte parse step
// Holds the record parse state and tags one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module nmrp_core #(
  parameter int MAX_RECORDS = nmrp_pkg::MaxRecordsDefault
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         step,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         last_byte,
  input  wire logic [nmrp_pkg::LimitW-1:0]  record_limit,
  output nmrp_pkg::result_t                 result
);
  import nmrp_pkg::*;

  localparam int CmpW = ($clog2(MAX_RECORDS + 1) > LimitW) ?
                        $clog2(MAX_RECORDS + 1) : LimitW;
  localparam logic [CmpW-1:0] MaxRec = CmpW'(MAX_RECORDS);

  localparam logic [1:0] StageType    = 2'd0;
  localparam logic [1:0] StageId      = 2'd1;
  localparam logic [1:0] StagePayload = 2'd2;

  typedef struct packed {
    field_kind_t phase;
    logic [31:0] remaining;
    logic        empty;
  } enter_t;

  // first nonempty field at or after the given stage
  function automatic enter_t enter_field(input logic [1:0] stage, input logic [7:0] tl,
                                         input logic [7:0] il, input logic [31:0] pl);
    enter_t e;
    e = '{phase: KIND_HEADER, remaining: 32'd0, empty: 1'b0};
    if (stage == StageType && tl != 8'd0) begin
      e.phase     = KIND_TYPE;
      e.remaining = {24'd0, tl};
    end else if (stage != StagePayload && il != 8'd0) begin
      e.phase     = KIND_ID;
      e.remaining = {24'd0, il};
    end else if (pl != 32'd0) begin
      e.phase     = KIND_PAYLOAD;
      e.remaining = pl;
    end else begin
      e.empty = 1'b1;
    end
    return e;
  endfunction

  field_kind_t phase, phase_next;
  logic [7:0]  header_flags, header_flags_next;
  logic [7:0]  type_length, type_length_next;
  logic [7:0]  id_length, id_length_next;
  logic [31:0] payload_length, payload_length_next;
  logic [1:0]  length_byte_count, length_byte_count_next;
  logic [31:0] bytes_remaining, bytes_remaining_next;
  logic [4:0]  record_count, record_count_next;

  logic        done;
  logic        use_enter;
  logic [1:0]  enter_stage;
  enter_t      ent;
  logic [31:0] remaining_dec;
  logic [4:0]  idx_raw;
  logic [CmpW-1:0] limit;
  logic [CmpW-1:0] limit_cfg;

  always_comb begin
    phase_next             = phase;
    header_flags_next      = header_flags;
    type_length_next       = type_length;
    id_length_next         = id_length;
    payload_length_next    = payload_length;
    length_byte_count_next = length_byte_count;
    bytes_remaining_next   = bytes_remaining;
    record_count_next      = record_count;
    use_enter              = 1'b0;
    enter_stage            = StageType;
    done                   = 1'b0;
    remaining_dec          = bytes_remaining - 32'd1;

    case (phase)
      KIND_HEADER: begin
        header_flags_next      = data_byte;
        type_length_next       = 8'd0;
        id_length_next         = 8'd0;
        payload_length_next    = 32'd0;
        length_byte_count_next = 2'd0;
        bytes_remaining_next   = 32'd0;
        if (record_count != 5'd31) record_count_next = record_count + 5'd1;
        phase_next = KIND_TYPE_LEN;
      end
      KIND_TYPE_LEN: begin
        type_length_next       = data_byte;
        payload_length_next    = 32'd0;
        length_byte_count_next = 2'd0;
        phase_next             = KIND_PAY_LEN;
      end
      KIND_PAY_LEN: begin
        payload_length_next = {payload_length[23:0], data_byte};
        if (header_flags[FlagSr] || length_byte_count == 2'd3) begin
          length_byte_count_next = 2'd0;
          if (header_flags[FlagIl]) phase_next = KIND_ID_LEN;
          else use_enter = 1'b1;
        end else begin
          length_byte_count_next = length_byte_count + 2'd1;
        end
      end
      KIND_ID_LEN: begin
        id_length_next = data_byte;
        use_enter      = 1'b1;
      end
      KIND_TYPE: begin
        bytes_remaining_next = remaining_dec;
        enter_stage          = StageId;
        use_enter            = (remaining_dec == 32'd0);
      end
      KIND_ID: begin
        bytes_remaining_next = remaining_dec;
        enter_stage          = StagePayload;
        use_enter            = (remaining_dec == 32'd0);
      end
      KIND_PAYLOAD: begin
        bytes_remaining_next = remaining_dec;
        done                 = (remaining_dec == 32'd0);
      end
      default: ;
    endcase

    ent = enter_field(enter_stage, type_length_next, id_length_next, payload_length_next);
    if (use_enter) begin
      if (ent.empty) begin
        done = 1'b1;
      end else begin
        phase_next           = ent.phase;
        bytes_remaining_next = ent.remaining;
      end
    end

    if (done) phase_next = header_flags_next[FlagMe] ? KIND_IGNORED : KIND_HEADER;

    // result tags
    idx_raw   = (record_count_next == 5'd0) ? 5'd0 : record_count_next - 5'd1;
    limit_cfg = CmpW'(record_limit);
    limit     = (limit_cfg < MaxRec) ? limit_cfg : MaxRec;

    result.byte_value   = data_byte;
    result.field_kind   = phase;
    result.record_index = (idx_raw > 5'd15) ? 4'd15 : idx_raw[3:0];
    result.record_tnf   = header_flags_next[2:0];
    result.begin_flag   = header_flags_next[FlagMb];
    result.chunk_flag   = header_flags_next[FlagCf];
    result.record_done  = done;
    result.message_done = done && header_flags_next[FlagMe];
    result.status       = ST_OK;
    if (phase != KIND_IGNORED) begin
      if (last_byte && !done) result.status = ST_TRUNCATED;
      else if (CmpW'(idx_raw) >= limit) result.status = ST_DROPPED;
    end

    // end of buffer: start afresh
    if (last_byte) begin
      phase_next             = KIND_HEADER;
      header_flags_next      = 8'd0;
      type_length_next       = 8'd0;
      id_length_next         = 8'd0;
      payload_length_next    = 32'd0;
      length_byte_count_next = 2'd0;
      bytes_remaining_next   = 32'd0;
      record_count_next      = 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= KIND_HEADER;
      header_flags      <= 8'd0;
      type_length       <= 8'd0;
      id_length         <= 8'd0;
      payload_length    <= 32'd0;
      length_byte_count <= 2'd0;
      bytes_remaining   <= 32'd0;
      record_count      <= 5'd0;
    end else if (step) begin
      phase             <= phase_next;
      header_flags      <= header_flags_next;
      type_length       <= type_length_next;
      id_length         <= id_length_next;
      payload_length    <= payload_length_next;
      length_byte_count <= length_byte_count_next;
      bytes_remaining   <= bytes_remaining_next;
      record_count      <= record_count_next;
    end
  end

endmodule

`default_nettype wire
